### rtl/vrac_pkg.sv
// vrac_pkg: widths, register indexes and word types for the vertex rotate unit.
// Used by vertex_rotate_about_center_unit. No dependencies.
`default_nettype none

package vrac_pkg;

    localparam int COORD_WIDTH    = 20;
    localparam int TRIG_FRAC_BITS = 14;

    localparam int TRIG_W   = 16;
    localparam int CFG_W    = 32;
    localparam int CENTER_W = COORD_WIDTH - 1;
    localparam int IDX_W    = 3;

    // growth of a coordinate through one rotation (c*a +/- s*b, then >> frac)
    localparam int GROW = (TRIG_W + 1 > TRIG_FRAC_BITS) ? (TRIG_W + 1 - TRIG_FRAC_BITS) : 0;

    localparam int D0 = COORD_WIDTH + 1;   // after center subtract
    localparam int D1 = D0 + GROW;         // after X rotation
    localparam int D2 = D1 + GROW;         // after Y rotation
    localparam int D3 = D2 + GROW;         // after Z rotation

    localparam int NSTAGE = 8;

    localparam logic [IDX_W-1:0] REG_X_TRIG   = 3'd0;
    localparam logic [IDX_W-1:0] REG_Y_TRIG   = 3'd1;
    localparam logic [IDX_W-1:0] REG_Z_TRIG   = 3'd2;
    localparam logic [IDX_W-1:0] REG_CENTER_X = 3'd3;
    localparam logic [IDX_W-1:0] REG_CENTER_Y = 3'd4;
    localparam logic [IDX_W-1:0] REG_CENTER_Z = 3'd5;

    localparam logic [CFG_W-1:0] TRIG_RESET = 32'h4000_0000;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] in_x;
        logic signed [COORD_WIDTH-1:0] in_y;
        logic signed [COORD_WIDTH-1:0] in_z;
    } t_in_word;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] out_x;
        logic signed [COORD_WIDTH-1:0] out_y;
        logic signed [COORD_WIDTH-1:0] out_z;
        logic                          saturated;
    } t_out_word;

endpackage

`default_nettype wire

### rtl/vertex_rotate_about_center_unit.sv
// vertex_rotate_about_center_unit: center-relative X/Y/Z Euler rotation of one vertex.
// Depends on vrac_pkg.
//
// One vertex word enters per clock unless all stages are full and the output stalls;
// its rotated word leaves through registered stages: center subtract, then per axis a
// multiply stage (four 16-bit by coordinate products) and a sum/round stage, then
// center add-back with saturation. Each stage has its own valid bit and holds only
// when the next is full and stalled, so input fills empty stages behind a held result.
// Registers are written through the cfg port and should only change while idle.
`default_nettype none

module vertex_rotate_about_center_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [vrac_pkg::IDX_W-1:0]   i_cfg_idx,
    input  wire logic [vrac_pkg::CFG_W-1:0]   i_cfg_data,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire vrac_pkg::t_in_word           i_in_word,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output vrac_pkg::t_out_word               o_out_word
);
    import vrac_pkg::*;

    localparam int PW0 = D0 + TRIG_W;
    localparam int PW1 = D1 + TRIG_W;
    localparam int PW2 = D2 + TRIG_W;
    localparam int SW0 = D0 + TRIG_W + 2;
    localparam int SW1 = D1 + TRIG_W + 2;
    localparam int SW2 = D2 + TRIG_W + 2;

    localparam logic signed [SW0-1:0] HALF0 = SW0'(1) <<< (TRIG_FRAC_BITS - 1);
    localparam logic signed [SW1-1:0] HALF1 = SW1'(1) <<< (TRIG_FRAC_BITS - 1);
    localparam logic signed [SW2-1:0] HALF2 = SW2'(1) <<< (TRIG_FRAC_BITS - 1);

    // configuration
    logic [CFG_W-1:0]    r_trig_x, r_trig_y, r_trig_z;
    logic [CENTER_W-1:0] r_cx, r_cy, r_cz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig_x <= TRIG_RESET;
            r_trig_y <= TRIG_RESET;
            r_trig_z <= TRIG_RESET;
            r_cx     <= '0;
            r_cy     <= '0;
            r_cz     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_X_TRIG:   r_trig_x <= i_cfg_data;
                REG_Y_TRIG:   r_trig_y <= i_cfg_data;
                REG_Z_TRIG:   r_trig_z <= i_cfg_data;
                REG_CENTER_X: r_cx     <= i_cfg_data[CENTER_W-1:0];
                REG_CENTER_Y: r_cy     <= i_cfg_data[CENTER_W-1:0];
                REG_CENTER_Z: r_cz     <= i_cfg_data[CENTER_W-1:0];
                default: ;
            endcase
        end
    end

    logic signed [TRIG_W-1:0] c_x, s_x, c_y, s_y, c_z, s_z;
    logic signed [D0-1:0]     cen_x, cen_y, cen_z;

    assign c_x   = r_trig_x[CFG_W-1:TRIG_W];
    assign s_x   = r_trig_x[TRIG_W-1:0];
    assign c_y   = r_trig_y[CFG_W-1:TRIG_W];
    assign s_y   = r_trig_y[TRIG_W-1:0];
    assign c_z   = r_trig_z[CFG_W-1:TRIG_W];
    assign s_z   = r_trig_z[TRIG_W-1:0];
    assign cen_x = $signed({2'b00, r_cx});
    assign cen_y = $signed({2'b00, r_cy});
    assign cen_z = $signed({2'b00, r_cz});

    // stage enables
    logic [NSTAGE-1:0] r_vld;
    logic [NSTAGE-1:0] en;

    always_comb begin
        en[NSTAGE-1] = !r_vld[NSTAGE-1] || i_out_ready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_ready  = en[0];
    assign o_out_valid = r_vld[NSTAGE-1];

    // stage 1: center subtract
    logic signed [D0-1:0] r_x1, r_y1, r_z1;
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_x1 <= D0'(i_in_word.in_x) - cen_x;
            r_y1 <= D0'(i_in_word.in_y) - cen_y;
            r_z1 <= D0'(i_in_word.in_z) - cen_z;
        end
    end

    // stage 2: X products
    logic signed [D0-1:0]  r_x2;
    logic signed [PW0-1:0] r_cy2, r_sz2, r_sy2, r_cz2;
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_x2  <= r_x1;
            r_cy2 <= c_x * r_y1;
            r_sz2 <= s_x * r_z1;
            r_sy2 <= s_x * r_y1;
            r_cz2 <= c_x * r_z1;
        end
    end

    // stage 3: X sums, rounded
    logic signed [SW0-1:0] sum_y3, sum_z3;
    assign sum_y3 = SW0'(r_cy2) - SW0'(r_sz2) + HALF0;
    assign sum_z3 = SW0'(r_sy2) + SW0'(r_cz2) + HALF0;

    logic signed [D1-1:0] r_x3, r_y3, r_z3;
    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_x3 <= D1'(r_x2);
            r_y3 <= D1'(sum_y3 >>> TRIG_FRAC_BITS);
            r_z3 <= D1'(sum_z3 >>> TRIG_FRAC_BITS);
        end
    end

    // stage 4: Y products
    logic signed [D1-1:0]  r_y4;
    logic signed [PW1-1:0] r_cx4, r_sz4, r_cz4, r_sx4;
    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_y4  <= r_y3;
            r_cx4 <= c_y * r_x3;
            r_sz4 <= s_y * r_z3;
            r_cz4 <= c_y * r_z3;
            r_sx4 <= s_y * r_x3;
        end
    end

    // stage 5: Y sums, rounded
    logic signed [SW1-1:0] sum_x5, sum_z5;
    assign sum_x5 = SW1'(r_cx4) + SW1'(r_sz4) + HALF1;
    assign sum_z5 = SW1'(r_cz4) - SW1'(r_sx4) + HALF1;

    logic signed [D2-1:0] r_x5, r_y5, r_z5;
    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_x5 <= D2'(sum_x5 >>> TRIG_FRAC_BITS);
            r_y5 <= D2'(r_y4);
            r_z5 <= D2'(sum_z5 >>> TRIG_FRAC_BITS);
        end
    end

    // stage 6: Z products
    logic signed [D2-1:0]  r_z6;
    logic signed [PW2-1:0] r_cx6, r_sy6, r_sx6, r_cy6;
    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_z6  <= r_z5;
            r_cx6 <= c_z * r_x5;
            r_sy6 <= s_z * r_y5;
            r_sx6 <= s_z * r_x5;
            r_cy6 <= c_z * r_y5;
        end
    end

    // stage 7: Z sums, rounded
    logic signed [SW2-1:0] sum_x7, sum_y7;
    assign sum_x7 = SW2'(r_cx6) - SW2'(r_sy6) + HALF2;
    assign sum_y7 = SW2'(r_sx6) + SW2'(r_cy6) + HALF2;

    logic signed [D3-1:0] r_x7, r_y7, r_z7;
    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r_x7 <= D3'(sum_x7 >>> TRIG_FRAC_BITS);
            r_y7 <= D3'(sum_y7 >>> TRIG_FRAC_BITS);
            r_z7 <= D3'(r_z6);
        end
    end

    // stage 8: center add-back and saturation
    logic signed [D3:0]          fin_x, fin_y, fin_z;
    logic signed [COORD_WIDTH-1:0] sat_x, sat_y, sat_z;
    logic                          clip_x, clip_y, clip_z;

    assign fin_x = (D3 + 1)'(r_x7) + (D3 + 1)'(cen_x);
    assign fin_y = (D3 + 1)'(r_y7) + (D3 + 1)'(cen_y);
    assign fin_z = (D3 + 1)'(r_z7) + (D3 + 1)'(cen_z);

    // fits when all bits from the target sign bit up agree
    assign clip_x = !((&fin_x[D3:COORD_WIDTH-1]) || !(|fin_x[D3:COORD_WIDTH-1]));
    assign clip_y = !((&fin_y[D3:COORD_WIDTH-1]) || !(|fin_y[D3:COORD_WIDTH-1]));
    assign clip_z = !((&fin_z[D3:COORD_WIDTH-1]) || !(|fin_z[D3:COORD_WIDTH-1]));

    assign sat_x = !clip_x ? fin_x[COORD_WIDTH-1:0]
                 : {fin_x[D3], {(COORD_WIDTH-1){!fin_x[D3]}}};
    assign sat_y = !clip_y ? fin_y[COORD_WIDTH-1:0]
                 : {fin_y[D3], {(COORD_WIDTH-1){!fin_y[D3]}}};
    assign sat_z = !clip_z ? fin_z[COORD_WIDTH-1:0]
                 : {fin_z[D3], {(COORD_WIDTH-1){!fin_z[D3]}}};

    t_out_word r_out;
    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r_out.out_x     <= sat_x;
            r_out.out_y     <= sat_y;
            r_out.out_z     <= sat_z;
            r_out.saturated <= clip_x || clip_y || clip_z;
        end
    end

    assign o_out_word = r_out;

endmodule

`default_nettype wire

### sim/tb_vertex_rotate_about_center_unit.sv
// Testbench for vertex_rotate_about_center_unit: random and directed vertices through
// a self-contained X/Y/Z rotation predictor. Depends on vrac_pkg and the unit RTL.
module tb_vertex_rotate_about_center_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import vrac_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int RST_CYCLES  = 10;
    localparam int PHASE_WORDS = 145;
    localparam int NUM_PHASES  = 8;
    localparam int LONG_HOLD   = 80;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_PRINT   = 40;

    localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;

    localparam longint COORD_HI = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
    localparam longint COORD_LO = -COORD_HI - 1;
    localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    typedef enum int {TRIG_ANGLE, TRIG_RAW, TRIG_EXTREME} t_trig_mode;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_we    = 1'b0;
    logic [IDX_W-1:0] i_cfg_idx   = '0;
    logic [CFG_W-1:0] i_cfg_data  = '0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_ready;
    t_in_word         i_in_word   = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_out_word        o_out_word;

    vertex_rotate_about_center_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    // shadow of the unit's registers
    logic [CFG_W-1:0]    trig_reg [3];
    logic [CENTER_W-1:0] ctr_reg  [3];

    t_in_word  vertex_q  [$];
    t_out_word rotated_q [$];

    int  queued_cnt   = 0;
    int  taken_cnt    = 0;
    int  seen_cnt     = 0;
    int  clip_cnt     = 0;
    int  err_cnt      = 0;
    int  cfg_cnt      = 0;
    int  cyc_cnt      = 0;
    int  in_block_cnt = 0;
    int  gap_left     = 0;
    int  hold_left    = 0;
    int  stall_req    = 0;
    int  stall_done   = 0;
    bit  idle_on      = 1'b1;
    bit  in_fire_q    = 1'b0;

    always #CLK_HALF i_clk = ~i_clk;

    function automatic longint round_q(longint v);
        return (v + (64'sd1 <<< (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
    endfunction

    // p = c*a - s*b, q = s*a + c*b, both rounded
    function automatic void turn_pair(input logic [CFG_W-1:0] cs, inout longint a,
                                      inout longint b);
        longint c, s, p, q;
        c = longint'($signed(cs[CFG_W-1 -: TRIG_W]));
        s = longint'($signed(cs[TRIG_W-1:0]));
        p = round_q(c * a - s * b);
        q = round_q(s * a + c * b);
        a = p;
        b = q;
    endfunction

    function automatic longint clamp_coord(longint v, inout bit clipped);
        if (v > COORD_HI) begin
            clipped = 1'b1;
            return COORD_HI;
        end
        if (v < COORD_LO) begin
            clipped = 1'b1;
            return COORD_LO;
        end
        return v;
    endfunction

    function automatic t_out_word rotate_vertex(t_in_word w);
        t_out_word r;
        longint    x, y, z, cx, cy, cz;
        bit        clipped;
        cx = longint'(ctr_reg[0]);
        cy = longint'(ctr_reg[1]);
        cz = longint'(ctr_reg[2]);
        x = longint'(w.in_x) - cx;
        y = longint'(w.in_y) - cy;
        z = longint'(w.in_z) - cz;
        clipped = 1'b0;
        turn_pair(trig_reg[0], y, z);
        turn_pair(trig_reg[1], z, x);
        turn_pair(trig_reg[2], x, y);
        r.out_x     = COORD_WIDTH'(clamp_coord(x + cx, clipped));
        r.out_y     = COORD_WIDTH'(clamp_coord(y + cy, clipped));
        r.out_z     = COORD_WIDTH'(clamp_coord(z + cz, clipped));
        r.saturated = clipped;
        return r;
    endfunction

    function automatic t_in_word mk_vertex(longint x, longint y, longint z);
        t_in_word w;
        w.in_x = COORD_WIDTH'(x);
        w.in_y = COORD_WIDTH'(y);
        w.in_z = COORD_WIDTH'(z);
        return w;
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] pick_extreme();
        case ($urandom_range(0, 4))
            0:       return C_MAX;
            1:       return C_MIN;
            2:       return '0;
            3:       return '1;
            default: return COORD_WIDTH'(1);
        endcase
    endfunction

    function automatic t_in_word random_vertex();
        t_in_word w;
        case ($urandom_range(0, 3))
            0: begin
                w.in_x = COORD_WIDTH'($urandom);
                w.in_y = COORD_WIDTH'($urandom);
                w.in_z = COORD_WIDTH'($urandom);
            end
            3: begin
                w.in_x = pick_extreme();
                w.in_y = pick_extreme();
                w.in_z = pick_extreme();
            end
            default: begin
                w.in_x = COORD_WIDTH'(longint'(ctr_reg[0])
                                      + longint'($urandom_range(0, 65535)) - 32768);
                w.in_y = COORD_WIDTH'(longint'(ctr_reg[1])
                                      + longint'($urandom_range(0, 65535)) - 32768);
                w.in_z = COORD_WIDTH'(longint'(ctr_reg[2])
                                      + longint'($urandom_range(0, 65535)) - 32768);
            end
        endcase
        return w;
    endfunction

    function automatic logic [CFG_W-1:0] pick_trig(t_trig_mode mode);
        real                      ang;
        logic signed [TRIG_W-1:0] c, s;
        case (mode)
            TRIG_RAW: return $urandom;
            TRIG_EXTREME: begin
                case ($urandom_range(0, 4))
                    0:       return 32'h8000_8000;
                    1:       return 32'h7FFF_7FFF;
                    2:       return 32'h0000_0000;
                    3:       return 32'h8000_7FFF;
                    default: return 32'h7FFF_8000;
                endcase
            end
            default: begin
                ang = real'($urandom_range(0, 62831)) / 10000.0;
                c = TRIG_W'($rtoi($cos(ang) * real'(1 << TRIG_FRAC_BITS)));
                s = TRIG_W'($rtoi($sin(ang) * real'(1 << TRIG_FRAC_BITS)));
                return {c, s};
            end
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_center();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return CFG_W'($urandom_range(20, 160) << 7);
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    task automatic note_mismatch(input string what, input longint got, input longint want);
        if (err_cnt < MAX_PRINT)
            $display("[%0t] MISMATCH word %0d %s: got %0d, want %0d", $realtime, seen_cnt,
                     what, got, want);
        err_cnt++;
    endtask

    task automatic set_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_X_TRIG:   trig_reg[0] = val;
            REG_Y_TRIG:   trig_reg[1] = val;
            REG_Z_TRIG:   trig_reg[2] = val;
            REG_CENTER_X: ctr_reg[0]  = val[CENTER_W-1:0];
            REG_CENTER_Y: ctr_reg[1]  = val[CENTER_W-1:0];
            REG_CENTER_Z: ctr_reg[2]  = val[CENTER_W-1:0];
            default: ;
        endcase
        cfg_cnt++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_rotation(input logic [CFG_W-1:0] tx, ty, tz, cx, cy, cz);
        set_reg(REG_X_TRIG, tx);
        set_reg(REG_Y_TRIG, ty);
        set_reg(REG_Z_TRIG, tz);
        set_reg(REG_CENTER_X, cx);
        set_reg(REG_CENTER_Y, cy);
        set_reg(REG_CENTER_Z, cz);
    endtask

    task automatic send(input t_in_word w);
        vertex_q.push_back(w);
        queued_cnt++;
    endtask

    task automatic drain();
        while (taken_cnt != queued_cnt || rotated_q.size() != 0)
            @(negedge i_clk);
    endtask

    // input driver
    always @(negedge i_clk) begin : drv
        logic     nxt_valid;
        t_in_word nxt_word;
        nxt_valid = i_in_valid;
        nxt_word  = i_in_word;
        if (i_rst_n && (!i_in_valid || in_fire_q)) begin
            nxt_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                gap_left = $urandom_range(0, 3);
            end else if (vertex_q.size() != 0) begin
                nxt_valid = 1'b1;
                nxt_word  = vertex_q.pop_front();
            end
        end
        i_in_valid <= nxt_valid;
        i_in_word  <= nxt_word;
    end

    // output back-pressure
    always @(negedge i_clk) begin : rcv
        logic nxt_ready;
        nxt_ready = 1'b1;
        if (hold_left > 0) begin
            hold_left--;
            nxt_ready = 1'b0;
        end else if (stall_done != stall_req) begin
            stall_done++;
            hold_left = LONG_HOLD - 1;
            nxt_ready = 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            hold_left = $urandom_range(0, 3);
            nxt_ready = 1'b0;
        end
        i_out_ready <= nxt_ready;
    end

    // monitor and checker
    always @(posedge i_clk) begin : mon
        t_out_word want;
        if (!i_rst_n) begin
            in_fire_q <= 1'b0;
        end else begin
            in_fire_q <= i_in_valid && o_in_ready;
            if (i_in_valid && !o_in_ready)
                in_block_cnt++;
            if (i_in_valid && o_in_ready) begin
                rotated_q.push_back(rotate_vertex(i_in_word));
                taken_cnt++;
            end
            if (o_out_valid && i_out_ready) begin
                seen_cnt++;
                if (o_out_word.saturated)
                    clip_cnt++;
                if (rotated_q.size() == 0) begin
                    note_mismatch("unexpected word, out_x", o_out_word.out_x, 0);
                end else begin
                    want = rotated_q.pop_front();
                    if (o_out_word.out_x !== want.out_x)
                        note_mismatch("out_x", o_out_word.out_x, want.out_x);
                    if (o_out_word.out_y !== want.out_y)
                        note_mismatch("out_y", o_out_word.out_y, want.out_y);
                    if (o_out_word.out_z !== want.out_z)
                        note_mismatch("out_z", o_out_word.out_z, want.out_z);
                    if (o_out_word.saturated !== want.saturated)
                        note_mismatch("saturated", o_out_word.saturated, want.saturated);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cyc_cnt++;
        if (cyc_cnt >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d words pending", cyc_cnt, rotated_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int directed;
        for (int i = 0; i < 3; i++) begin
            trig_reg[i] = TRIG_RESET;
            ctr_reg[i]  = '0;
        end
        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // unused indexes must not disturb anything
        set_reg(REG_SPARE_A, '1);
        set_reg(REG_SPARE_B, 32'h1234_5678);

        // identity rotation from reset
        send(mk_vertex(0, 0, 0));
        send(mk_vertex(C_MAX, C_MAX, C_MAX));
        send(mk_vertex(C_MIN, C_MIN, C_MIN));
        send(mk_vertex(C_MAX, C_MIN, 0));
        send(mk_vertex(-1, 1, -1));
        drain();

        // cos = 0.5, sin = 0: odd inputs hit exact rounding ties
        load_rotation(32'h2000_0000, 32'h2000_0000, 32'h2000_0000, 0, 0, 0);
        send(mk_vertex(1, -1, 3));
        send(mk_vertex(-3, 5, -5));
        send(mk_vertex(C_MAX, C_MIN, -1));
        drain();

        // +/-2.0 extreme trig and max center (high bits masked off): growth and clipping
        load_rotation(32'h8000_8000, 32'h8000_7FFF, 32'h7FFF_8000, '1, '1, '1);
        send(mk_vertex(C_MAX, C_MAX, C_MAX));
        send(mk_vertex(C_MIN, C_MIN, C_MIN));
        send(mk_vertex(C_MIN, C_MAX, C_MIN));
        send(mk_vertex(C_MAX, 0, C_MIN));
        send(mk_vertex(1, -1, 0));
        drain();

        // quarter turn on each axis about a terminal-sized center
        load_rotation(32'h0000_4000, 32'h0000_4000, 32'h0000_4000, 10240, 3072, 0);
        send(mk_vertex(10240, 3072, 0));
        send(mk_vertex(10496, 3072, 256));
        send(mk_vertex(0, 0, 0));
        send(mk_vertex(C_MIN, C_MAX, 5));
        drain();
        directed = queued_cnt;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            t_trig_mode mode;
            mode = (ph == 5) ? TRIG_EXTREME : ((ph % 2) ? TRIG_RAW : TRIG_ANGLE);
            idle_on = (ph != 4) && (ph < NUM_PHASES - 2);
            load_rotation(pick_trig(mode), pick_trig(mode), pick_trig(mode),
                          pick_center(), pick_center(), pick_center());
            if (ph == 2)
                stall_req++;
            repeat (PHASE_WORDS) send(random_vertex());
            drain();
        end

        repeat (NSTAGE * 4) @(posedge i_clk);
        $display("Run: %0d vertices (%0d directed), %0d results, %0d register writes",
                 taken_cnt, directed, seen_cnt, cfg_cnt);
        $display("Run: %0d saturated results, %0d cycles with input held off", clip_cnt,
                 in_block_cnt);
        if (err_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
